>>> src/dmhs_pkg.sv
// ----------------------------------------------------------------------------
// dmhs_pkg: shared types and codes of the docking mode handshake sequencer
// Event kinds, phases, actions, reject codes and the structs that pass
// between the top level and the sequencing core.
// ----------------------------------------------------------------------------
package dmhs_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [2:0] {
        EV_DEST     = 3'd0,
        EV_STATE    = 3'd1,
        EV_DOCKED   = 3'd2,
        EV_EMERG    = 3'd3,
        EV_NAV_DONE = 3'd4,
        EV_TICK     = 3'd5
    } ev_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_AUTO = 3'd1,
        PH_NAV       = 3'd2,
        PH_WAIT_ADM  = 3'd3,
        PH_EMERG     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_MODE   = 2'd1,
        ACT_GOAL   = 2'd2,
        ACT_CANCEL = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        REJ_NONE       = 4'd0,
        REJ_UNDOCKED   = 4'd1,
        REJ_STOP       = 4'd2,
        REJ_EMERG      = 4'd3,
        REJ_RECOVERING = 4'd4,
        REJ_BUSY       = 4'd5,
        REJ_NO_GOAL    = 4'd6,
        REJ_NOT_AUTO   = 4'd7,
        REJ_EMERG_BLK  = 4'd8
    } reject_t;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ADMIT = 2'd1;
    localparam logic [1:0] MODE_AUTO  = 2'd2;

    localparam logic [3:0] CTRL_STOP    = 4'd0;
    localparam logic [3:0] CTRL_ADMIT   = 4'd1;
    localparam logic [3:0] CTRL_AUTO    = 4'd2;
    localparam logic [3:0] CTRL_UNKNOWN = 4'd8;

    localparam logic [1:0] CFG_AUTO_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_ADMIT_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_RETRIES   = 2'd2;

    typedef struct packed {
        logic [7:0] auto_timeout_ticks;
        logic [7:0] admit_timeout_ticks;
        logic [2:0] max_retries;
    } cfg_t;

    typedef struct packed {
        ev_kind_t     func;
        logic [2:0]   value;
        logic [31:0]  goal_x;
        logic [31:0]  goal_y;
    } event_t;

    typedef struct packed {
        action_t      action;
        logic [1:0]   mode_value;
        logic [31:0]  out_x;
        logic [31:0]  out_y;
        reject_t      reject_code;
        phase_t       phase_now;
        logic         retry_failed;
    } result_t;

endpackage

>>> src/dmhs_core.sv
// ----------------------------------------------------------------------------
// dmhs_core: sequencing state and event decision logic
// Holds the phase, the latest controller flags, the pending goal and the
// timers. The result of the presented item is combinational; the state is
// updated at the edge where the item is processed.
// ----------------------------------------------------------------------------
module dmhs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dmhs_pkg::event_t  ev,
    input  dmhs_pkg::cfg_t    cfg,
    output dmhs_pkg::result_t res
);
    import dmhs_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [3:0]  ctrl_reg,     ctrl_next;
    logic        docked_reg,   docked_next;
    logic        emerg_reg,    emerg_next;
    logic        pending_reg,  pending_next;
    logic [31:0] held_x_reg,   held_x_next;
    logic [31:0] held_y_reg,   held_y_next;
    logic [7:0]  elapsed_reg,  elapsed_next;
    logic [2:0]  retry_reg,    retry_next;
    logic        exh_reg,      exh_next;
    logic [7:0]  elapsed_inc;

    assign elapsed_inc = (elapsed_reg == 8'hFF) ? elapsed_reg : elapsed_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            ctrl_reg    <= CTRL_UNKNOWN;
            docked_reg  <= 1'b0;
            emerg_reg   <= 1'b0;
            pending_reg <= 1'b0;
            elapsed_reg <= 8'd0;
            retry_reg   <= 3'd0;
            exh_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            ctrl_reg    <= ctrl_next;
            docked_reg  <= docked_next;
            emerg_reg   <= emerg_next;
            pending_reg <= pending_next;
            elapsed_reg <= elapsed_next;
            retry_reg   <= retry_next;
            exh_reg     <= exh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ctrl_next    = ctrl_reg;
        docked_next  = docked_reg;
        emerg_next   = emerg_reg;
        pending_next = pending_reg;
        held_x_next  = held_x_reg;
        held_y_next  = held_y_reg;
        elapsed_next = elapsed_reg;
        retry_next   = retry_reg;
        exh_next     = exh_reg;

        res.action      = ACT_NONE;
        res.mode_value  = MODE_NONE;
        res.out_x       = 32'd0;
        res.out_y       = 32'd0;
        res.reject_code = REJ_NONE;

        unique case (ev.func)
            EV_DEST:
            begin
                if (!docked_reg)
                    res.reject_code = REJ_UNDOCKED;
                else if (ctrl_reg == CTRL_STOP)
                    res.reject_code = REJ_STOP;
                else if (emerg_reg)
                    res.reject_code = REJ_EMERG;
                else if (phase_reg == PH_EMERG)
                    res.reject_code = REJ_RECOVERING;
                else if (phase_reg != PH_IDLE)
                    res.reject_code = REJ_BUSY;
                else
                begin
                    held_x_next = ev.goal_x;
                    held_y_next = ev.goal_y;
                    if (ctrl_reg == CTRL_AUTO)
                    begin
                        res.action   = ACT_GOAL;
                        res.out_x    = ev.goal_x;
                        res.out_y    = ev.goal_y;
                        pending_next = 1'b0;
                        phase_next   = PH_NAV;
                    end
                    else
                    begin
                        res.action     = ACT_MODE;
                        res.mode_value = MODE_AUTO;
                        pending_next   = 1'b1;
                        phase_next     = PH_WAIT_AUTO;
                        elapsed_next   = 8'd0;
                    end
                end
            end
            EV_STATE:
            begin
                ctrl_next = {1'b0, ev.value};
                if (ctrl_next == CTRL_STOP
                    && (phase_reg == PH_NAV || phase_reg == PH_WAIT_AUTO))
                begin
                    pending_next = 1'b0;
                    phase_next   = PH_IDLE;
                    if (phase_reg == PH_NAV)
                        res.action = ACT_CANCEL;
                end
                else if (phase_reg == PH_EMERG && !emerg_reg && ctrl_next == CTRL_ADMIT)
                begin
                    phase_next   = PH_IDLE;
                    pending_next = 1'b0;
                end
                else if (phase_reg == PH_WAIT_AUTO && ctrl_next == CTRL_AUTO
                         && pending_reg && !emerg_reg)
                begin
                    res.action   = ACT_GOAL;
                    res.out_x    = held_x_reg;
                    res.out_y    = held_y_reg;
                    pending_next = 1'b0;
                    phase_next   = PH_NAV;
                end
                else if (phase_reg == PH_WAIT_ADM && ctrl_next == CTRL_ADMIT)
                begin
                    phase_next = PH_IDLE;
                    retry_next = 3'd0;
                    exh_next   = 1'b0;
                end
            end
            EV_DOCKED:
            begin
                docked_next = ev.value[0];
            end
            EV_EMERG:
            begin
                emerg_next = ev.value[0];
                if (ev.value[0] && !emerg_reg)
                begin
                    pending_next = 1'b0;
                    phase_next   = PH_EMERG;
                    if (phase_reg == PH_NAV || phase_reg == PH_WAIT_AUTO)
                        res.action = ACT_CANCEL;
                end
                else if (!ev.value[0] && emerg_reg && phase_reg == PH_EMERG
                         && ctrl_reg == CTRL_ADMIT)
                begin
                    phase_next   = PH_IDLE;
                    pending_next = 1'b0;
                end
            end
            EV_NAV_DONE:
            begin
                if (ev.value[0] && phase_reg == PH_NAV)
                begin
                    if (emerg_reg)
                        phase_next = PH_EMERG;
                    else if (ctrl_reg == CTRL_ADMIT)
                        phase_next = PH_IDLE;
                    else
                    begin
                        res.action     = ACT_MODE;
                        res.mode_value = MODE_ADMIT;
                        phase_next     = PH_WAIT_ADM;
                        retry_next     = 3'd0;
                        exh_next       = 1'b0;
                        elapsed_next   = 8'd0;
                    end
                end
            end
            EV_TICK:
            begin
                if (!emerg_reg && phase_reg == PH_WAIT_AUTO)
                begin
                    if (elapsed_inc < cfg.auto_timeout_ticks)
                        elapsed_next = elapsed_inc;
                    else
                    begin
                        pending_next   = 1'b0;
                        res.action     = ACT_MODE;
                        res.mode_value = MODE_ADMIT;
                        phase_next     = PH_WAIT_ADM;
                        retry_next     = 3'd0;
                        exh_next       = 1'b0;
                        elapsed_next   = 8'd0;
                    end
                end
                else if (!emerg_reg && phase_reg == PH_WAIT_ADM && !exh_reg)
                begin
                    if (elapsed_inc < cfg.admit_timeout_ticks)
                        elapsed_next = elapsed_inc;
                    else if (retry_reg >= cfg.max_retries)
                    begin
                        elapsed_next = elapsed_inc;
                        exh_next     = 1'b1;
                    end
                    else
                    begin
                        retry_next     = retry_reg + 3'd1;
                        res.action     = ACT_MODE;
                        res.mode_value = MODE_ADMIT;
                        elapsed_next   = 8'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.phase_now    = phase_next;
        res.retry_failed = exh_next;
    end

endmodule

>>> src/docking_mode_handshake_sequencer.sv
// ----------------------------------------------------------------------------
// docking_mode_handshake_sequencer: navigation mode handshake sequencer
// Sequences destination, controller state, flag and tick events into mode
// commands, goal releases and cancels for a motor controller.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the s_ stream: s_tuser carries the event kind and s_tdata
// the controller state or flag, followed by the destination x and y. Each
// event gives exactly one result item on the m_ stream: m_tuser carries the
// action and m_tdata the mode, goal, reject code, phase and retry status.
// An event is registered on entry, decided against the sequencer state and
// registered again at the output. One event per cycle is sustained while
// m_tready stays high; the single decision stage, which updates all state,
// sets that rate. When the receiver stalls, the output register holds its
// item and the input register still takes one more event before s_tready
// falls. The cfg_ channel writes the timeout and retry registers and is
// always ready; write it only while no events are in flight. Reset clears
// the phase to idle, the controller state to unknown, all flags, the timers
// and the valid bits of both pipeline registers, and loads the register
// defaults.
// ----------------------------------------------------------------------------
module docking_mode_handshake_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Fields from bit 0: value[2:0], goal_x[31:0], goal_y[31:0], zero pad.
    input  logic [dmhs_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Fields from bit 0: func[2:0].
    input  logic [dmhs_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: mode_value[1:0], out_x[31:0], out_y[31:0],
    // reject_code[3:0], phase_now[2:0], retry_failed, zero pad.
    output logic [dmhs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Fields from bit 0: action[1:0].
    output logic [dmhs_pkg::OUT_TUSER_W-1:0]     m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dmhs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dmhs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import dmhs_pkg::*;

    cfg_t    cfg_reg;
    event_t  in_ev_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    logic    out_valid_reg;
    result_t core_res;
    logic    out_adv;
    logic    fire;
    logic    s_accept;

    assign out_adv   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_timeout_ticks  <= 8'd20;
            cfg_reg.admit_timeout_ticks <= 8'd10;
            cfg_reg.max_retries         <= 3'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_AUTO_TIMEOUT:  cfg_reg.auto_timeout_ticks  <= cfg_data;
                CFG_ADMIT_TIMEOUT: cfg_reg.admit_timeout_ticks <= cfg_data;
                CFG_MAX_RETRIES:   cfg_reg.max_retries         <= cfg_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_ev_reg.func   <= ev_kind_t'(s_tuser);
            in_ev_reg.value  <= s_tdata[2:0];
            in_ev_reg.goal_x <= s_tdata[34:3];
            in_ev_reg.goal_y <= s_tdata[66:35];
        end
        if (fire)
            out_res_reg <= core_res;
    end

    dmhs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ev    (in_ev_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {6'd0,
                       out_res_reg.retry_failed,
                       out_res_reg.phase_now,
                       out_res_reg.reject_code,
                       out_res_reg.out_y,
                       out_res_reg.out_x,
                       out_res_reg.mode_value};

    a_goal_means_nav: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.action == ACT_GOAL
        |-> out_res_reg.phase_now == PH_NAV)
        else $error("goal released without entering navigation");

    a_mode_only_with_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_res_reg.action == ACT_MODE)
                           == (out_res_reg.mode_value != MODE_NONE)))
        else $error("mode value does not match the mode command action");

    a_reject_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.reject_code != REJ_NONE
        |-> out_res_reg.action == ACT_NONE)
        else $error("rejected event produced an action");

    a_stalled_event_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_ev_reg))
        else $error("pending event lost while the output was stalled");

endmodule

>>> tb/docking_mode_handshake_sequencer_tb.sv
// ----------------------------------------------------------------------------
// docking_mode_handshake_sequencer_tb: self-checking bench for the sequencer
// A fixed table of events drives the sequencer through its reject codes,
// goal release, cancel and emergency recovery paths. Random missions follow
// under several timeout and retry settings and three stall patterns. Every
// result item is checked against its table row or a behavioral copy of the phase machine.
// ----------------------------------------------------------------------------
module docking_mode_handshake_sequencer_tb;

    import dmhs_pkg::*;

    localparam int DIR_ROWS = 25;
    localparam logic [2:0] EV_UNUSED_6 = 3'd6;
    localparam logic [2:0] EV_UNUSED_7 = 3'd7;
    localparam logic [2:0] ST_STOP  = CTRL_STOP[2:0];
    localparam logic [2:0] ST_ADMIT = CTRL_ADMIT[2:0];
    localparam logic [2:0] ST_AUTO  = CTRL_AUTO[2:0];

    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  value;
        logic [31:0] x;
        logic [31:0] y;
        bit          typed;
        action_t     act;
        logic [1:0]  mode;
        reject_t     rej;
        phase_t      ph;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int settings_done = 1;

    result_t pending_results [$];

    cfg_t        seq_cfg;
    phase_t      seq_phase;
    logic [3:0]  seq_ctrl;
    bit          seq_docked;
    bit          seq_emerg;
    bit          seq_goal_held;
    logic [31:0] seq_x;
    logic [31:0] seq_y;
    logic [7:0]  seq_elapsed;
    logic [2:0]  seq_retries;
    bit          seq_exhausted;
    result_t     step_out;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{EV_DEST, 3'b000, 32'h7fffffff, 32'h80000000, 1'b1,
          ACT_NONE, MODE_NONE, REJ_UNDOCKED, PH_IDLE},
        '{EV_UNUSED_6, 3'b111, 32'hffffffff, 32'hffffffff, 1'b1,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_UNUSED_7, 3'b000, 32'h00000000, 32'h00000000, 1'b1,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DOCKED, 3'b111, 32'h0, 32'h0, 1'b1,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_STATE, ST_STOP, 32'h0, 32'h0, 1'b1,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DEST, 3'b000, 32'h12345678, 32'h9abcdef0, 1'b1,
          ACT_NONE, MODE_NONE, REJ_STOP, PH_IDLE},
        '{EV_STATE, ST_ADMIT, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DEST, 3'b000, 32'h80000000, 32'h7fffffff, 1'b1,
          ACT_MODE, MODE_AUTO, REJ_NONE, PH_WAIT_AUTO},
        '{EV_DEST, 3'b000, 32'h0, 32'h0, 1'b1,
          ACT_NONE, MODE_NONE, REJ_BUSY, PH_WAIT_AUTO},
        '{EV_TICK, 3'b111, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_STATE, ST_AUTO, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_NAV_DONE, 3'b110, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_NAV_DONE, 3'b001, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_TICK, 3'b000, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_STATE, ST_ADMIT, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_EMERG, 3'b001, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_EMERG, 3'b011, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_TICK, 3'b000, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DEST, 3'b000, 32'h55555555, 32'haaaaaaaa, 1'b1,
          ACT_NONE, MODE_NONE, REJ_EMERG, PH_EMERG},
        '{EV_EMERG, 3'b000, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_STATE, ST_AUTO, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DEST, 3'b000, 32'h00000001, 32'hffffffff, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_EMERG, 3'b101, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_EMERG, 3'b110, 32'h0, 32'h0, 1'b0,
          ACT_NONE, MODE_NONE, REJ_NONE, PH_IDLE},
        '{EV_DEST, 3'b000, 32'hfffffffe, 32'h00000002, 1'b1,
          ACT_NONE, MODE_NONE, REJ_RECOVERING, PH_EMERG}
    };

    docking_mode_handshake_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void release_goal();
        if (!seq_goal_held)
        begin
            step_out.reject_code = REJ_NO_GOAL;
            seq_phase = PH_IDLE;
        end
        else if (seq_ctrl != CTRL_AUTO)
            step_out.reject_code = REJ_NOT_AUTO;
        else if (seq_emerg)
            step_out.reject_code = REJ_EMERG_BLK;
        else
        begin
            step_out.action = ACT_GOAL;
            step_out.out_x = seq_x;
            step_out.out_y = seq_y;
            seq_goal_held = 1'b0;
            seq_phase = PH_NAV;
        end
    endfunction

    function automatic void request_admittance();
        step_out.action = ACT_MODE;
        step_out.mode_value = MODE_ADMIT;
        seq_phase = PH_WAIT_ADM;
        seq_retries = '0;
        seq_exhausted = 1'b0;
        seq_elapsed = '0;
    endfunction

    function automatic result_t advance_sequencer(input logic [2:0] kind,
                                                  input logic [2:0] value,
                                                  input logic [31:0] x,
                                                  input logic [31:0] y);
        bit was_emerg;
        bit active;
        step_out = '0;
        step_out.action = ACT_NONE;
        step_out.reject_code = REJ_NONE;
        case (kind)
            EV_DEST:
            begin
                if (!seq_docked)
                    step_out.reject_code = REJ_UNDOCKED;
                else if (seq_ctrl == CTRL_STOP)
                    step_out.reject_code = REJ_STOP;
                else if (seq_emerg)
                    step_out.reject_code = REJ_EMERG;
                else if (seq_phase == PH_EMERG)
                    step_out.reject_code = REJ_RECOVERING;
                else if (seq_phase != PH_IDLE)
                    step_out.reject_code = REJ_BUSY;
                else
                begin
                    seq_x = x;
                    seq_y = y;
                    seq_goal_held = 1'b1;
                    if (seq_ctrl == CTRL_AUTO)
                        release_goal();
                    else
                    begin
                        step_out.action = ACT_MODE;
                        step_out.mode_value = MODE_AUTO;
                        seq_phase = PH_WAIT_AUTO;
                        seq_elapsed = '0;
                    end
                end
            end
            EV_STATE:
            begin
                seq_ctrl = {1'b0, value};
                if (seq_ctrl == CTRL_STOP && (seq_phase == PH_NAV || seq_phase == PH_WAIT_AUTO))
                begin
                    if (seq_phase == PH_NAV)
                        step_out.action = ACT_CANCEL;
                    seq_goal_held = 1'b0;
                    seq_phase = PH_IDLE;
                end
                else if (seq_phase == PH_EMERG && !seq_emerg && seq_ctrl == CTRL_ADMIT)
                begin
                    seq_phase = PH_IDLE;
                    seq_goal_held = 1'b0;
                end
                else if (seq_phase == PH_WAIT_AUTO && seq_ctrl == CTRL_AUTO && seq_goal_held
                         && !seq_emerg)
                    release_goal();
                else if (seq_phase == PH_WAIT_ADM && seq_ctrl == CTRL_ADMIT)
                begin
                    seq_phase = PH_IDLE;
                    seq_retries = '0;
                    seq_exhausted = 1'b0;
                end
            end
            EV_DOCKED:
                seq_docked = value[0];
            EV_EMERG:
            begin
                was_emerg = seq_emerg;
                seq_emerg = value[0];
                if (value[0] && !was_emerg)
                begin
                    active = (seq_phase == PH_NAV || seq_phase == PH_WAIT_AUTO);
                    seq_goal_held = 1'b0;
                    seq_phase = PH_EMERG;
                    if (active)
                        step_out.action = ACT_CANCEL;
                end
                else if (!value[0] && was_emerg && seq_phase == PH_EMERG
                         && seq_ctrl == CTRL_ADMIT)
                begin
                    seq_phase = PH_IDLE;
                    seq_goal_held = 1'b0;
                end
            end
            EV_NAV_DONE:
            begin
                if (value[0] && seq_phase == PH_NAV)
                begin
                    if (seq_emerg)
                        seq_phase = PH_EMERG;
                    else if (seq_ctrl == CTRL_ADMIT)
                        seq_phase = PH_IDLE;
                    else
                        request_admittance();
                end
            end
            EV_TICK:
            begin
                if (!seq_emerg && seq_phase == PH_WAIT_AUTO)
                begin
                    if (seq_elapsed != 8'hff)
                        seq_elapsed = seq_elapsed + 8'd1;
                    if (seq_elapsed >= seq_cfg.auto_timeout_ticks)
                    begin
                        seq_goal_held = 1'b0;
                        request_admittance();
                    end
                end
                else if (!seq_emerg && seq_phase == PH_WAIT_ADM && !seq_exhausted)
                begin
                    if (seq_elapsed != 8'hff)
                        seq_elapsed = seq_elapsed + 8'd1;
                    if (seq_elapsed >= seq_cfg.admit_timeout_ticks)
                    begin
                        if (seq_retries >= seq_cfg.max_retries)
                            seq_exhausted = 1'b1;
                        else
                        begin
                            seq_retries = seq_retries + 3'd1;
                            step_out.action = ACT_MODE;
                            step_out.mode_value = MODE_ADMIT;
                            seq_elapsed = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        step_out.phase_now = seq_phase;
        step_out.retry_failed = seq_exhausted;
        return step_out;
    endfunction

    function automatic logic [31:0] any_coord();
        case ($urandom_range(15))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] flag_val(input bit f);
        return {2'($urandom_range(3)), f};
    endfunction

    function automatic logic [2:0] pick_ctrl();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return ST_ADMIT;
        else if (r < 80)
            return ST_AUTO;
        else if (r < 85)
            return ST_STOP;
        return 3'($urandom_range(7));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: result %0d %s expected %0h actual %0h",
                         $time, results_checked, name, want_v, got_v);
        end
    endfunction

    task automatic send_event(input logic [2:0] kind, input logic [2:0] value,
                              input logic [31:0] x, input logic [31:0] y,
                              input bit typed = 1'b0, input result_t given = '0);
        result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {5'b0, y, x, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = advance_sequencer(kind, value, x, y);
        if (typed)
            want = given;
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n > 300 ? 300 : n)
            send_event(EV_TICK, 3'($urandom_range(7)), $urandom, $urandom);
    endtask

    task automatic send_noise();
        send_event(3'($urandom_range(7)), 3'($urandom_range(7)), any_coord(), any_coord());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_AUTO_TIMEOUT:  seq_cfg.auto_timeout_ticks = data;
            CFG_ADMIT_TIMEOUT: seq_cfg.admit_timeout_ticks = data;
            CFG_MAX_RETRIES:   seq_cfg.max_retries = data[2:0];
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_mission();
        int admit_eff;
        if (!seq_docked || $urandom_range(7) == 0)
            send_event(EV_DOCKED, flag_val($urandom_range(9) != 0), $urandom, $urandom);
        send_event(EV_STATE, pick_ctrl(), $urandom, $urandom);
        send_event(EV_DEST, 3'($urandom_range(7)), any_coord(), any_coord());
        if ($urandom_range(3) == 0)
            send_ticks($urandom_range(0, int'(seq_cfg.auto_timeout_ticks) + 1));
        else
            send_ticks($urandom_range(0, 2));
        if ($urandom_range(7) == 0)
        begin
            send_event(EV_EMERG, flag_val(1'b1), $urandom, $urandom);
            send_ticks($urandom_range(0, 3));
            if ($urandom_range(1) == 0)
                send_event(EV_NAV_DONE, flag_val(1'b1), $urandom, $urandom);
            if ($urandom_range(1) == 0)
                send_event(EV_DEST, 3'($urandom_range(7)), any_coord(), any_coord());
            send_event(EV_EMERG, flag_val(1'b0), $urandom, $urandom);
            send_event(EV_STATE, pick_ctrl(), $urandom, $urandom);
        end
        if ($urandom_range(4) != 0)
            send_event(EV_STATE, ST_AUTO, $urandom, $urandom);
        repeat ($urandom_range(0, 2)) send_noise();
        if ($urandom_range(9) == 0)
            send_event(EV_STATE, ST_STOP, $urandom, $urandom);
        send_event(EV_NAV_DONE, flag_val($urandom_range(9) != 0), $urandom, $urandom);
        admit_eff = (seq_cfg.admit_timeout_ticks == 8'd0) ? 1 : int'(seq_cfg.admit_timeout_ticks);
        send_ticks($urandom_range(0, admit_eff * (int'(seq_cfg.max_retries) + 1) + 2));
        if ($urandom_range(6) != 0)
            send_event(EV_STATE, ST_ADMIT, $urandom, $urandom);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: expected no result, actual tuser %0h tdata %0h",
                             $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("action", 32'(want.action), 32'(m_tuser[1:0]));
                check_field("mode_value", 32'(want.mode_value), 32'(m_tdata[1:0]));
                check_field("out_x", want.out_x, m_tdata[33:2]);
                check_field("out_y", want.out_y, m_tdata[65:34]);
                check_field("reject_code", 32'(want.reject_code), 32'(m_tdata[69:66]));
                check_field("phase_now", 32'(want.phase_now), 32'(m_tdata[72:70]));
                check_field("retry_failed", 32'(want.retry_failed), 32'(m_tdata[73]));
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        result_t given;
        logic [7:0] auto_v;
        logic [7:0] admit_v;
        logic [2:0] retries_v;
        int budget;
        seq_cfg.auto_timeout_ticks = 8'd20;
        seq_cfg.admit_timeout_ticks = 8'd10;
        seq_cfg.max_retries = 3'd3;
        seq_phase = PH_IDLE;
        seq_ctrl = CTRL_UNKNOWN;
        seq_docked = 1'b0;
        seq_emerg = 1'b0;
        seq_goal_held = 1'b0;
        seq_x = '0;
        seq_y = '0;
        seq_elapsed = '0;
        seq_retries = '0;
        seq_exhausted = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 62;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            given = '0;
            given.action = dir_tab[i].act;
            given.mode_value = dir_tab[i].mode;
            given.reject_code = dir_tab[i].rej;
            given.phase_now = dir_tab[i].ph;
            send_event(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].x, dir_tab[i].y,
                       dir_tab[i].typed, given);
        end

        for (int stall_set = 0; stall_set < 3; stall_set++)
        begin
            for (int cfg_set = 0; cfg_set < 4; cfg_set++)
            begin
                settle();
                case (stall_set)
                    0:
                    begin
                        send_idle_pct = 24;
                        recv_idle_pct = 62;
                    end
                    1:
                    begin
                        send_idle_pct = 62;
                        recv_idle_pct = 24;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                case (cfg_set)
                    0:
                    begin
                        auto_v = 8'd1;
                        admit_v = 8'd1;
                        retries_v = 3'd0;
                    end
                    1:
                    begin
                        auto_v = 8'd0;
                        admit_v = 8'd0;
                        retries_v = 3'd7;
                    end
                    2:
                    begin
                        auto_v = 8'd255;
                        admit_v = 8'd255;
                        retries_v = 3'd7;
                    end
                    default:
                    begin
                        auto_v = 8'($urandom_range(2, 15));
                        admit_v = 8'($urandom_range(1, 8));
                        retries_v = 3'($urandom_range(7));
                    end
                endcase
                write_reg(CFG_AUTO_TIMEOUT, auto_v);
                write_reg(CFG_ADMIT_TIMEOUT, admit_v);
                write_reg(CFG_MAX_RETRIES, {5'($urandom_range(31)), retries_v});
                settings_done++;
                budget = items_sent + ((cfg_set == 2) ? 40 : 80);
                while (items_sent < budget)
                    run_mission();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d results expected but never seen", $time, pending_results.size());
        end
        $display("Sent %0d events, %0d from the directed table, under %0d register settings.",
                 items_sent, DIR_ROWS, settings_done);
        $display("Checked %0d results across three stall patterns, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
